// ----- rtl/phrl_pkg.sv -----
package phrl_pkg;

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_CHECK = 2'd1,
		OP_QUERY = 2'd2,
		OP_TICK  = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] host_address;
		logic [15:0] rate_limit;
	} req_t;

	typedef struct packed {
		logic allowed;
		logic known;
		logic add_failed;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_READ,
		ST_EXEC,
		ST_RET_RD,
		ST_RET_CHK,
		ST_RET_CNT,
		ST_DONE
	} st_t;

	localparam logic [15:0] WINDOW_RESET = 16'd1000;

endpackage

// ----- rtl/phrl_front.sv -----
module phrl_front
	import phrl_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  req_t in_data,
	output logic q_valid,
	input  logic q_pop,
	output req_t q_data
);

	// two-entry queue decoupling acceptance from execution
	req_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	wire push = in_valid && !in_stall;

	assign in_stall = (cnt_q == 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_data   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

endmodule

// ----- rtl/phrl_back.sv -----
module phrl_back
	import phrl_pkg::*;
#(
	parameter int HOST_ENTRIES  = 64,
	parameter int PENDING_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [15:0] window,
	input  logic        q_valid,
	output logic        q_pop,
	input  req_t        q_data,
	output logic        out_valid,
	input  logic        out_stall,
	output rsp_t        out_data
);

	localparam int HW = (HOST_ENTRIES > 1) ? $clog2(HOST_ENTRIES) : 1;
	localparam int PW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
	localparam int UW = $clog2(PENDING_DEPTH + 1);
	localparam int HC = $clog2(HOST_ENTRIES + 1);

	// key memory is scanned one entry at a time, in SCAN then READ
	logic [31:0] key_mem   [HOST_ENTRIES];
	logic [15:0] limit_mem [HOST_ENTRIES];
	logic [15:0] count_mem [HOST_ENTRIES];
	logic [HW-1:0] pidx_mem [PENDING_DEPTH];
	logic [31:0] pdue_mem  [PENDING_DEPTH];
	logic [HOST_ENTRIES-1:0] valid_q;

	st_t st_q, st_d;
	req_t req_q;
	logic [HC-1:0] scan_q;
	logic hit_q, free_q;
	logic [HW-1:0] hidx_q, fidx_q;
	logic [31:0] key_rd_q, due_rd_q;
	logic [15:0] lim_rd_q, cnt_rd_q;
	logic [HW-1:0] pidx_rd_q;
	logic [PW-1:0] head_q, tail_q;
	logic [UW-1:0] used_q;
	logic [31:0] now_q;
	rsp_t rsp_q;
	logic ov_q;

	wire [HW-1:0] sidx = scan_q[HW-1:0];
	wire scan_last = (scan_q == HC'(HOST_ENTRIES - 1));
	wire key_match = valid_q[sidx] && (key_rd_q == req_q.host_address);
	wire [HW-1:0] tidx = hit_q ? hidx_q : fidx_q;
	wire grant = hit_q && (cnt_rd_q < lim_rd_q) && (used_q != UW'(PENDING_DEPTH));
	wire [31:0] age = now_q - due_rd_q;
	wire [PW-1:0] head_n = (head_q == PW'(PENDING_DEPTH - 1)) ? '0 : head_q + 1'b1;
	wire [PW-1:0] tail_n = (tail_q == PW'(PENDING_DEPTH - 1)) ? '0 : tail_q + 1'b1;

	assign q_pop = (st_q == ST_IDLE) && q_valid && !ov_q;
	assign out_valid = ov_q;
	assign out_data = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= ST_IDLE;
		else st_q <= st_d;
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: begin
				if (q_pop) st_d = (q_data.operation == OP_TICK) ? ST_RET_RD : ST_SCAN;
			end
			ST_SCAN: st_d = ST_READ;
			ST_READ: begin
				if (key_match || scan_last) st_d = ST_EXEC;
				else st_d = ST_SCAN;
			end
			ST_EXEC:    st_d = ST_DONE;
			ST_RET_RD:  st_d = (used_q == '0) ? ST_DONE : ST_RET_CHK;
			ST_RET_CHK: st_d = age[31] ? ST_DONE : ST_RET_CNT;
			ST_RET_CNT: st_d = ST_RET_RD;
			ST_DONE:    st_d = ST_IDLE;
			default:    st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ST_SCAN: key_rd_q <= key_mem[sidx];
			ST_READ: begin
				lim_rd_q <= limit_mem[key_match ? sidx : hidx_q];
				cnt_rd_q <= count_mem[key_match ? sidx : hidx_q];
			end
			ST_EXEC: begin
				if (req_q.operation == OP_ADD && (hit_q || free_q)) begin
					key_mem[tidx] <= req_q.host_address;
					limit_mem[tidx] <= req_q.rate_limit;
					count_mem[tidx] <= '0;
				end else if (req_q.operation == OP_CHECK && grant) begin
					count_mem[hidx_q] <= cnt_rd_q + 16'd1;
					pidx_mem[tail_q] <= hidx_q;
					pdue_mem[tail_q] <= now_q + {16'd0, window};
				end
			end
			ST_RET_RD: begin
				pidx_rd_q <= pidx_mem[head_q];
				due_rd_q <= pdue_mem[head_q];
			end
			ST_RET_CHK: cnt_rd_q <= count_mem[pidx_rd_q];
			ST_RET_CNT: begin
				if (cnt_rd_q != '0) count_mem[pidx_rd_q] <= cnt_rd_q - 16'd1;
			end
			default: ;
		endcase
		if (q_pop) req_q <= q_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			scan_q <= '0;
			hit_q <= 1'b0;
			free_q <= 1'b0;
			hidx_q <= '0;
			fidx_q <= '0;
			head_q <= '0;
			tail_q <= '0;
			used_q <= '0;
			now_q <= '0;
			rsp_q <= '0;
			ov_q <= 1'b0;
		end else begin
			if (ov_q && !out_stall) ov_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					scan_q <= '0;
					hit_q <= 1'b0;
					free_q <= 1'b0;
					// the result stays put until its beat is taken
					if (q_pop) rsp_q <= '0;
					if (q_pop && q_data.operation == OP_TICK) now_q <= now_q + 32'd1;
				end
				ST_READ: begin
					if (key_match) begin
						hit_q <= 1'b1;
						hidx_q <= sidx;
					end
					if (!valid_q[sidx] && !free_q) begin
						free_q <= 1'b1;
						fidx_q <= sidx;
					end
					scan_q <= scan_q + 1'b1;
				end
				ST_EXEC: begin
					case (req_q.operation)
						OP_ADD: begin
							if (hit_q || free_q) begin
								valid_q[tidx] <= 1'b1;
								rsp_q.known <= 1'b1;
							end else rsp_q.add_failed <= 1'b1;
						end
						OP_CHECK: begin
							rsp_q.known <= hit_q;
							rsp_q.allowed <= grant;
							if (grant) begin
								tail_q <= tail_n;
								used_q <= used_q + 1'b1;
							end
						end
						default: rsp_q.known <= hit_q;
					endcase
				end
				ST_RET_CNT: begin
					head_q <= head_n;
					used_q <= used_q - 1'b1;
				end
				ST_DONE: ov_q <= 1'b1;
				default: ;
			endcase
		end
	end

endmodule

// ----- rtl/per_host_sliding_window_rate_limiter.sv -----
// Per-host request limiter over a sliding window of ticks. Beats enter a
// two-deep queue; the back end handles one at a time. Add, check and query
// scan the host table one entry at a time, stopping on a key match or at the
// last entry; a tick retires due expiries in order from the single-port
// expiry queue memory, stopping at the first one not yet due. The back
// end takes its next beat the cycle after the result beat is accepted.
// The user writes window_ticks through cfg_we/cfg_data only while the
// block is idle; the block itself does not enforce this. Reset value 1000.
module per_host_sliding_window_rate_limiter
	import phrl_pkg::*;
#(
	parameter int HOST_ENTRIES  = 64,
	parameter int PENDING_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  req_t        in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output rsp_t        out_data
);

	logic [15:0] window_q;
	logic q_valid, q_pop;
	req_t q_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) window_q <= WINDOW_RESET;
		else if (cfg_we) window_q <= cfg_data;
	end

	phrl_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .in_data,
		.q_valid, .q_pop, .q_data
	);

	phrl_back #(.HOST_ENTRIES(HOST_ENTRIES), .PENDING_DEPTH(PENDING_DEPTH)) u_back (
		.clk, .arst_n, .window(window_q), .q_valid, .q_pop, .q_data,
		.out_valid, .out_stall, .out_data
	);

	a_one_hot_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.allowed && out_data.add_failed))
		else $error("allowed and add_failed together");
	a_allowed_known: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.allowed |-> out_data.known)
		else $error("grant for unknown host");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

endmodule

// ----- test/per_host_sliding_window_rate_limiter_tb.sv -----
`timescale 1ns / 100ps

class limiter_scoreboard;
	logic [15:0] window;
	bit          host_used[64];
	logic [31:0] host_key[64];
	logic [15:0] host_limit[64];
	logic [15:0] host_count[64];
	int          exp_host[$];
	logic [31:0] exp_due[$];
	logic [31:0] now;
	phrl_pkg::rsp_t pending_rsp[$];
	int mismatches;

	function new();
		window = phrl_pkg::WINDOW_RESET;
		now = 0;
		mismatches = 0;
		foreach (host_used[i]) host_used[i] = 0;
	endfunction

	function int find_host(logic [31:0] key);
		foreach (host_used[i])
			if (host_used[i] && host_key[i] == key) return i;
		return -1;
	endfunction

	// Predict one beat's response and update the table and expiry queue.
	function void note_request(phrl_pkg::req_t req);
		phrl_pkg::rsp_t rsp;
		int idx;
		rsp = '0;
		case (phrl_pkg::op_t'(req.operation))
			phrl_pkg::OP_ADD: begin
				idx = find_host(req.host_address);
				if (idx < 0)
					foreach (host_used[i])
						if (!host_used[i] && idx < 0) idx = i;
				if (idx < 0) begin
					rsp.add_failed = 1;
				end else begin
					host_used[idx] = 1;
					host_key[idx] = req.host_address;
					host_limit[idx] = req.rate_limit;
					host_count[idx] = 0;
					rsp.known = 1;
				end
			end
			phrl_pkg::OP_CHECK: begin
				idx = find_host(req.host_address);
				if (idx >= 0) begin
					rsp.known = 1;
					if (host_count[idx] < host_limit[idx] && exp_host.size() < 256) begin
						host_count[idx]++;
						exp_host.push_back(idx);
						exp_due.push_back(now + window);
						rsp.allowed = 1;
					end
				end
			end
			phrl_pkg::OP_QUERY: rsp.known = find_host(req.host_address) >= 0;
			default: begin
				logic [31:0] d;
				now++;
				while (exp_host.size() > 0) begin
					d = now - exp_due[0];
					if (d[31]) break;
					if (host_count[exp_host[0]] > 0) host_count[exp_host[0]]--;
					void'(exp_host.pop_front());
					void'(exp_due.pop_front());
				end
			end
		endcase
		pending_rsp.push_back(rsp);
	endfunction

	function void check_response(phrl_pkg::rsp_t got);
		phrl_pkg::rsp_t want;
		if (pending_rsp.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) $display("unexpected response %b", got);
			return;
		end
		want = pending_rsp.pop_front();
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("response mismatch: expected a/k/f=%b actual %b", want, got);
		end
	endfunction
endclass

module per_host_sliding_window_rate_limiter_tb;
	import phrl_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [15:0] cfg_data = '0;
	logic in_valid = 0;
	logic in_stall;
	req_t in_data = '0;
	logic out_valid;
	logic out_stall = 0;
	rsp_t out_data;

	limiter_scoreboard sb = new();
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_off = 0;
	int quiet_cycles = 0;
	logic [31:0] addr_pool[16];

	per_host_sliding_window_rate_limiter u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	// receiver: sample at rise, pick next stall at fall
	always @(posedge clk) begin
		if (out_valid && !out_stall) sb.check_response(out_data);
		if ((out_valid && !out_stall) || (in_valid && !in_stall)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 20000) begin
			$display("FAIL");
			$finish;
		end
	end

	always @(negedge clk)
		out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);

	// valid stays up after the beat; the next beat or drain() drops or reloads it
	task automatic send_beat(logic [1:0] op, logic [31:0] addr, logic [15:0] lim);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_data <= '{operation: op, host_address: addr, rate_limit: lim};
		in_valid <= 1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_request(in_data);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.pending_rsp.size() > 0) @(negedge clk);
		repeat (300) @(negedge clk);
	endtask

	task automatic write_window(logic [15:0] w);
		drain();
		cfg_we <= 1;
		cfg_data <= w;
		@(negedge clk);
		cfg_we <= 0;
		sb.window = w;
	endtask

	// mostly checks on a small host pool so limits and expiries get exercised
	task automatic random_beat();
		logic [1:0] op;
		logic [31:0] addr;
		int r;
		r = $urandom_range(99);
		op = r < 12 ? OP_ADD : r < 62 ? OP_CHECK : r < 72 ? OP_QUERY : OP_TICK;
		addr = $urandom_range(9) == 0 ? $urandom : addr_pool[$urandom_range(15)];
		send_beat(op, addr, 16'($urandom_range(3) == 0 ? $urandom : $urandom_range(6)));
	endtask

	initial begin
		// pool hosts that are in the table once it has filled up
		foreach (addr_pool[i]) addr_pool[i] = 32'h0a00_0000 + 32'(i * 3);
		addr_pool[0] = '0;
		addr_pool[1] = '1;
		repeat (5) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: extremes, zero limit, overwrite, unknown host, full table
		write_window(16'd2);
		send_beat(OP_QUERY, 32'h0, 16'h0);
		send_beat(OP_CHECK, 32'hffff_ffff, 16'h0);
		send_beat(OP_ADD, 32'h0, 16'h0);
		send_beat(OP_CHECK, 32'h0, 16'hffff);
		send_beat(OP_ADD, 32'hffff_ffff, 16'hffff);
		send_beat(OP_CHECK, 32'hffff_ffff, 16'h0);
		send_beat(OP_CHECK, 32'hffff_ffff, 16'h0);
		send_beat(OP_ADD, 32'hffff_ffff, 16'd1);
		send_beat(OP_CHECK, 32'hffff_ffff, 16'h0);
		send_beat(OP_CHECK, 32'hffff_ffff, 16'h0);
		send_beat(OP_QUERY, 32'hffff_ffff, 16'h0);
		send_beat(OP_TICK, 32'h0, 16'h0);
		write_window(16'd0);
		send_beat(OP_ADD, 32'h1234_5678, 16'd2);
		send_beat(OP_CHECK, 32'h1234_5678, 16'h0);
		send_beat(OP_TICK, 32'h0, 16'h0);
		send_beat(OP_CHECK, 32'h1234_5678, 16'h0);
		for (int i = 0; i < 64; i++) send_beat(OP_ADD, 32'h0a00_0000 + i, 16'd3);
		send_beat(OP_QUERY, 32'h0a00_003f, 16'h0);

		// window lowered after a long expiry: later grants wait behind it
		write_window(16'd40);
		send_beat(OP_CHECK, 32'h0a00_0001, 16'h0);
		write_window(16'd1);
		send_beat(OP_CHECK, 32'h0a00_0002, 16'h0);
		send_beat(OP_TICK, 32'h0, 16'h0);
		send_beat(OP_TICK, 32'h0, 16'h0);

		// fill the expiry queue to its depth
		for (int i = 0; i < 64; i++) send_beat(OP_ADD, 32'h0a00_0000 + i, 16'hffff);
		for (int i = 0; i < 260; i++) send_beat(OP_CHECK, 32'h0a00_0000 + i % 32, 16'h0);

		// receiver holds off while the sender keeps offering
		fork
			begin
				hold_off = 1;
				repeat (400) @(negedge clk);
				hold_off = 0;
			end
			for (int i = 0; i < 40; i++) send_beat(OP_QUERY, $urandom, 16'h0);
		join
		drain();

		// the long expiry falls due and the whole queue retires behind it
		for (int i = 0; i < 40; i++) send_beat(OP_TICK, 32'h0, 16'h0);

		write_window(16'd3);
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = phase == 0 ? 31 : phase == 1 ? 74 : 0;
			recv_idle_pct = phase == 0 ? 74 : phase == 1 ? 31 : 0;
			for (int i = 0; i < 60; i++) send_beat(OP_ADD, addr_pool[i % 16], 16'd4);
			for (int i = 0; i < 327; i++) random_beat();
			write_window(phase == 0 ? 16'd1 : phase == 1 ? 16'd20 : 16'd1000);
		end
		drain();
		if (sb.mismatches == 0 && sb.pending_rsp.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule

// ----- files.f -----
rtl/phrl_pkg.sv
rtl/phrl_front.sv
rtl/phrl_back.sv
rtl/per_host_sliding_window_rate_limiter.sv
test/per_host_sliding_window_rate_limiter_tb.sv
